### src/i2cm_pkg.sv
package i2cm_pkg;

	// command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_SCL   = 3'd5;

	// config register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 1'd1;

	localparam logic [7:0] PHASE_TICKS_RST   = 8'd1;
	localparam logic [7:0] STRETCH_LIMIT_RST = 8'd100;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_byte;
		logic       give_ack;
		logic       scl_force_level;
		logic       scl_in;
		logic       sda_in;
	} i2cm_tick_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       nack;
		logic       scl_seen;
	} i2cm_res_t;

	typedef struct packed {
		logic [3:0] step;
		logic [2:0] cmd;
		logic [2:0] bit_cnt;
		logic [7:0] shreg;
		logic [7:0] dly;
		logic [7:0] str;
		logic       ack;
		logic [7:0] rx;
		logic       nack;
		logic       scl;
		logic       sda;
	} i2cm_state_t;

endpackage

### src/i2cm_if.sv
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] write_byte;
	logic       give_ack;
	logic       scl_force_level;
	logic       scl_in;
	logic       sda_in;

	modport source (output valid, command, write_byte, give_ack, scl_force_level, scl_in,
		sda_in, input ready);
	modport sink (input valid, command, write_byte, give_ack, scl_force_level, scl_in,
		sda_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_drive_low;
	logic       sda_drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       nack;
	logic       scl_seen;

	modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
		read_byte, nack, scl_seen, input ready);
	modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
		read_byte, nack, scl_seen, output ready);
endinterface

interface i2cm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [i2cm_pkg::CFG_IDX_W-1:0]   idx;
	logic [7:0]                       wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

### src/i2cm_step.sv
module i2cm_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  i2cm_pkg::i2cm_tick_t tick,
	input  logic [7:0]           phase_ticks,
	input  logic [7:0]           stretch_limit,
	output i2cm_pkg::i2cm_res_t  res
);

	// start / stop steps
	localparam logic [3:0] SS_DRV0 = 4'd0;
	localparam logic [3:0] SS_DRV1 = 4'd2;
	localparam logic [3:0] SS_DRV2 = 4'd4;
	localparam logic [3:0] SS_LAST = 4'd5;
	// write steps
	localparam logic [3:0] W_BIT     = 4'd0;
	localparam logic [3:0] W_SCL_HI  = 4'd1;
	localparam logic [3:0] W_STR     = 4'd2;
	localparam logic [3:0] W_SCL_LO  = 4'd4;
	localparam logic [3:0] W_ACK_REL = 4'd5;
	localparam logic [3:0] W_ACK_HI  = 4'd6;
	localparam logic [3:0] W_ACK_STR = 4'd7;
	localparam logic [3:0] W_ACK_SMP = 4'd8;
	localparam logic [3:0] W_LAST    = 4'd9;
	// read steps
	localparam logic [3:0] R_FIRST   = 4'd0;
	localparam logic [3:0] R_SCL_HI  = 4'd1;
	localparam logic [3:0] R_STR     = 4'd2;
	localparam logic [3:0] R_SMP     = 4'd3;
	localparam logic [3:0] R_SCL_LO  = 4'd5;
	localparam logic [3:0] R_ACK_DRV = 4'd6;
	localparam logic [3:0] R_ACK_HI  = 4'd7;
	localparam logic [3:0] R_ACK_STR = 4'd8;
	localparam logic [3:0] R_LAST    = 4'd10;

	localparam logic [2:0] BIT_LAST = 3'd7;

	i2cm_pkg::i2cm_state_t st_q, st_n;
	logic       is_str, adv, loop_bit, done;
	logic [7:0] limit, dly_inc;
	logic [3:0] last;

	// line changes made on entry to a step
	function automatic i2cm_pkg::i2cm_state_t enter_step(input i2cm_pkg::i2cm_state_t s);
		i2cm_pkg::i2cm_state_t r;
		r = s;
		r.dly = '0;
		r.str = '0;
		case (s.cmd)
			i2cm_pkg::CMD_START: begin
				case (s.step)
					SS_DRV0: begin
						r.scl = 1'b0;
						r.sda = 1'b0;
					end
					SS_DRV1: r.sda = 1'b1;
					SS_DRV2: r.scl = 1'b1;
					default: ;
				endcase
			end
			i2cm_pkg::CMD_STOP: begin
				case (s.step)
					SS_DRV0: r.sda = 1'b1;
					SS_DRV1: r.scl = 1'b0;
					SS_DRV2: r.sda = 1'b0;
					default: ;
				endcase
			end
			i2cm_pkg::CMD_WRITE: begin
				case (s.step) inside
					W_BIT: begin
						r.sda   = ~s.shreg[7];
						r.shreg = {s.shreg[6:0], 1'b0};
					end
					W_SCL_HI, W_ACK_HI: r.scl = 1'b0;
					W_SCL_LO, W_LAST:   r.scl = 1'b1;
					W_ACK_REL:          r.sda = 1'b0;
					default: ;
				endcase
			end
			i2cm_pkg::CMD_READ: begin
				case (s.step) inside
					R_SCL_HI, R_ACK_HI: r.scl = 1'b0;
					R_SCL_LO, R_LAST:   r.scl = 1'b1;
					R_ACK_DRV:          r.sda = s.ack;
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	always_comb begin
		st_n     = st_q;
		adv      = 1'b0;
		done     = 1'b0;
		limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
		dly_inc  = st_q.dly + 8'd1;
		is_str   = ((st_q.cmd == i2cm_pkg::CMD_WRITE) &&
		            (st_q.step == W_STR || st_q.step == W_ACK_STR)) ||
		           ((st_q.cmd == i2cm_pkg::CMD_READ) &&
		            (st_q.step == R_STR || st_q.step == R_ACK_STR));
		loop_bit = (st_q.bit_cnt != BIT_LAST) &&
		           (((st_q.cmd == i2cm_pkg::CMD_WRITE) && (st_q.step == W_SCL_LO)) ||
		            ((st_q.cmd == i2cm_pkg::CMD_READ) && (st_q.step == R_SCL_LO)));
		if (st_q.cmd == i2cm_pkg::CMD_WRITE)
			last = W_LAST;
		else if (st_q.cmd == i2cm_pkg::CMD_READ)
			last = R_LAST;
		else
			last = SS_LAST;

		if (en) begin
			if (st_q.cmd != i2cm_pkg::CMD_NONE) begin
				if (is_str) begin
					// wait while the slave holds SCL low, bounded
					if (!tick.scl_in && (st_q.str < stretch_limit))
						st_n.str = st_q.str + 8'd1;
					else
						adv = 1'b1;
				end else begin
					st_n.dly = dly_inc;
					if (dly_inc >= limit) begin
						if ((st_q.cmd == i2cm_pkg::CMD_WRITE) && (st_q.step == W_ACK_SMP))
							st_n.nack = tick.sda_in;
						if ((st_q.cmd == i2cm_pkg::CMD_READ) && (st_q.step == R_SMP))
							st_n.shreg = {st_q.shreg[6:0], tick.sda_in};
						adv = 1'b1;
					end
				end
				if (adv) begin
					if (loop_bit) begin
						st_n.bit_cnt = st_q.bit_cnt + 3'd1;
						st_n.step    = W_BIT;
						st_n         = enter_step(st_n);
					end else if (st_q.step >= last) begin
						if (st_q.cmd == i2cm_pkg::CMD_READ) begin
							st_n.sda = 1'b0;
							st_n.rx  = st_n.shreg;
						end
						st_n.cmd     = i2cm_pkg::CMD_NONE;
						st_n.step    = SS_DRV0;
						st_n.bit_cnt = '0;
						st_n.dly     = '0;
						st_n.str     = '0;
						done         = 1'b1;
					end else begin
						st_n.step = st_q.step + 4'd1;
						st_n      = enter_step(st_n);
					end
				end
			end else if ((tick.command >= i2cm_pkg::CMD_START) &&
			             (tick.command <= i2cm_pkg::CMD_READ)) begin
				st_n.cmd     = tick.command;
				st_n.step    = R_FIRST;
				st_n.bit_cnt = '0;
				if (tick.command == i2cm_pkg::CMD_WRITE)
					st_n.shreg = tick.write_byte;
				if (tick.command == i2cm_pkg::CMD_READ) begin
					st_n.ack   = tick.give_ack;
					st_n.shreg = '0;
					st_n.sda   = 1'b0;
				end
				st_n = enter_step(st_n);
			end else if (tick.command == i2cm_pkg::CMD_SCL) begin
				st_n.scl = ~tick.scl_force_level;
				done     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= st_n;
		end
	end

	always_comb begin
		res.scl_drive_low = st_n.scl;
		res.sda_drive_low = st_n.sda;
		res.busy_res      = (st_n.cmd != i2cm_pkg::CMD_NONE);
		res.done_res      = done;
		res.read_byte     = st_n.rx;
		res.nack          = st_n.nack;
		res.scl_seen      = tick.scl_in;
	end

endmodule

### src/i2c_master_byte_engine.sv
// Open-drain I2C master, driven one bus tick per word.
// tick channel: one word per clock tick carrying the sampled SCL/SDA levels and,
//   while idle, an optional command (start, stop, write byte, read byte, set SCL).
//   Commands arriving while a sequence runs are dropped, as are unused codes.
// res channel: exactly one word per tick word, in order, carrying the line drives
//   after that tick, busy/done flags, last read byte, last ACK sample and SCL seen.
// cfg channel: phase_ticks (index 0) and stretch_limit (index 1); always ready;
//   the user must write them only while the engine is idle; the block does not enforce it.
// A tick word is registered in the input stage, then its result in the result register.
// Throughput: one word per cycle while res is taken; the sequencer is a single registered step
//   between the input stage and the result register.
// Stall: when res is not taken, the result register holds, the input stage holds,
//   and tick.ready drops once both are full; nothing is lost or repeated.
// Reset (arst_n low): drives released, engine idle, read_byte and nack zero,
//   phase_ticks = 1, stretch_limit = 100, both pipeline stages empty.
module i2c_master_byte_engine (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_in_if.sink    tick,
	i2cm_out_if.source res,
	i2cm_cfg_if.sink   cfg
);

	logic                  v_s1;     // input stage full
	i2cm_pkg::i2cm_tick_t  tick_s1;
	logic                  out_v_q;  // result register full
	i2cm_pkg::i2cm_res_t   res_q;
	i2cm_pkg::i2cm_res_t   core_res;
	logic [7:0]            phase_q;
	logic [7:0]            stretch_q;
	logic                  out_free;
	logic                  fire;

	// result register can take a word when empty or being drained
	assign out_free   = !out_v_q || res.ready;
	assign fire       = v_s1 && out_free;
	assign tick.ready = !v_s1 || out_free;
	assign cfg.ready  = 1'b1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.command         <= tick.command;
			tick_s1.write_byte      <= tick.write_byte;
			tick_s1.give_ack        <= tick.give_ack;
			tick_s1.scl_force_level <= tick.scl_force_level;
			tick_s1.scl_in          <= tick.scl_in;
			tick_s1.sda_in          <= tick.sda_in;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cm_pkg::PHASE_TICKS_RST;
			stretch_q <= i2cm_pkg::STRETCH_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				i2cm_pkg::CFG_PHASE_TICKS:   phase_q   <= cfg.wdata;
				i2cm_pkg::CFG_STRETCH_LIMIT: stretch_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// sequencer: state advances once per tick word
	i2cm_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fire),
		.tick          (tick_s1),
		.phase_ticks   (phase_q),
		.stretch_limit (stretch_q),
		.res           (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign res.valid         = out_v_q;
	assign res.scl_drive_low = res_q.scl_drive_low;
	assign res.sda_drive_low = res_q.sda_drive_low;
	assign res.busy_res      = res_q.busy_res;
	assign res.done_res      = res_q.done_res;
	assign res.read_byte     = res_q.read_byte;
	assign res.nack          = res_q.nack;
	assign res.scl_seen      = res_q.scl_seen;

`ifndef SYNTHESIS
	// a finished sequence or SCL force never leaves the engine busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("done_res with busy_res set");

	// a held input word stays put until the sequencer consumes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_free) |=> (v_s1 && $stable(tick_s1)))
		else $error("input stage lost or changed a word while stalled");

	// every sequencer step fills the result register
	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_v_q)
		else $error("sequencer step produced no result word");
`endif

endmodule

### tb/i2cm_checker.sv
`timescale 1ns / 100ps

module i2cm_checker (
	input  logic clk,
	input  logic arst_n,
	i2cm_in_if   tick,
	i2cm_out_if  res,
	i2cm_cfg_if  cfg,
	output int   mismatches,
	output int   results_owed,
	output logic engine_idle
);
	import i2cm_pkg::*;

	// step positions with special meaning
	localparam logic [3:0] WR_BIT_LAST = 4'd4;  // last step of one data bit
	localparam logic [3:0] WR_ACK_HOLD = 4'd8;  // ACK sampled at end of this delay
	localparam logic [3:0] WR_LAST     = 4'd9;
	localparam logic [3:0] RD_SAMPLE   = 4'd3;  // data bit sampled at end of this delay
	localparam logic [3:0] RD_BIT_LAST = 4'd5;
	localparam logic [3:0] RD_LAST     = 4'd10;
	localparam logic [3:0] FRAME_LAST  = 4'd5;  // start and stop chains

	logic [7:0] phase_cfg;
	logic [7:0] stretch_cfg;

	logic [3:0] seq_step;
	logic [2:0] cur_cmd;
	logic [2:0] bit_idx;
	logic [7:0] shifter;
	logic [7:0] delay_cnt;
	logic [7:0] stretch_cnt;
	logic       ack_sel;
	logic [7:0] rx_byte;
	logic       nack_bit;
	logic       scl_low;
	logic       sda_low;

	i2cm_res_t  lines_due[$];
	i2cm_tick_t word_in;
	i2cm_res_t  seen;
	i2cm_res_t  want;
	int         bad_count = 0;

	assign mismatches = bad_count;

	// line changes made on entry to a step
	function automatic void enter_step();
		delay_cnt   = '0;
		stretch_cnt = '0;
		case (cur_cmd)
		CMD_START: begin
			if (seq_step == 4'd0) begin
				scl_low = 1'b0;
				sda_low = 1'b0;
			end else if (seq_step == 4'd2) begin
				sda_low = 1'b1;
			end else if (seq_step == 4'd4) begin
				scl_low = 1'b1;
			end
		end
		CMD_STOP: begin
			if (seq_step == 4'd0) begin
				sda_low = 1'b1;
			end else if (seq_step == 4'd2) begin
				scl_low = 1'b0;
			end else if (seq_step == 4'd4) begin
				sda_low = 1'b0;
			end
		end
		CMD_WRITE: begin
			if (seq_step == 4'd0) begin
				sda_low = ~shifter[7];
				shifter = {shifter[6:0], 1'b0};
			end else if (seq_step == 4'd1 || seq_step == 4'd6) begin
				scl_low = 1'b0;
			end else if (seq_step == WR_BIT_LAST || seq_step == WR_LAST) begin
				scl_low = 1'b1;
			end else if (seq_step == 4'd5) begin
				sda_low = 1'b0;
			end
		end
		CMD_READ: begin
			if (seq_step == 4'd1 || seq_step == 4'd7) begin
				scl_low = 1'b0;
			end else if (seq_step == RD_BIT_LAST || seq_step == RD_LAST) begin
				scl_low = 1'b1;
			end else if (seq_step == 4'd6) begin
				sda_low = ack_sel;
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic logic in_stretch_step();
		if (cur_cmd == CMD_WRITE)
			return seq_step == 4'd2 || seq_step == 4'd7;
		if (cur_cmd == CMD_READ)
			return seq_step == 4'd2 || seq_step == 4'd8;
		return 1'b0;
	endfunction

	// moves to the following step; returns 1 when the chain ends
	function automatic logic next_step();
		logic [3:0] last;
		if (((cur_cmd == CMD_WRITE && seq_step == WR_BIT_LAST) ||
			(cur_cmd == CMD_READ && seq_step == RD_BIT_LAST)) && bit_idx < 3'd7) begin
			bit_idx  = bit_idx + 3'd1;
			seq_step = '0;
			enter_step();
			return 1'b0;
		end
		case (cur_cmd)
		CMD_WRITE: last = WR_LAST;
		CMD_READ:  last = RD_LAST;
		default:   last = FRAME_LAST;
		endcase
		if (seq_step >= last) begin
			if (cur_cmd == CMD_READ) begin
				sda_low = 1'b0;
				rx_byte = shifter;
			end
			cur_cmd     = CMD_NONE;
			seq_step    = '0;
			bit_idx     = '0;
			delay_cnt   = '0;
			stretch_cnt = '0;
			return 1'b1;
		end
		seq_step = seq_step + 4'd1;
		enter_step();
		return 1'b0;
	endfunction

	// one bus tick through the engine, giving the word it must answer with
	function automatic i2cm_res_t advance_engine(input i2cm_tick_t t);
		i2cm_res_t  r;
		logic       done;
		logic [7:0] limit;
		done = 1'b0;
		if (cur_cmd != CMD_NONE) begin
			if (in_stretch_step()) begin
				if (!t.scl_in && stretch_cnt < stretch_cfg)
					stretch_cnt = stretch_cnt + 8'd1;
				else
					done = next_step();
			end else begin
				limit     = (phase_cfg == 8'd0) ? 8'd1 : phase_cfg;
				delay_cnt = delay_cnt + 8'd1;
				if (delay_cnt >= limit) begin
					if (cur_cmd == CMD_WRITE && seq_step == WR_ACK_HOLD)
						nack_bit = t.sda_in;
					if (cur_cmd == CMD_READ && seq_step == RD_SAMPLE)
						shifter = {shifter[6:0], t.sda_in};
					done = next_step();
				end
			end
		end else if (t.command >= CMD_START && t.command <= CMD_READ) begin
			cur_cmd  = t.command;
			seq_step = '0;
			bit_idx  = '0;
			if (t.command == CMD_WRITE)
				shifter = t.write_byte;
			if (t.command == CMD_READ) begin
				ack_sel = t.give_ack;
				shifter = '0;
				sda_low = 1'b0;
			end
			enter_step();
		end else if (t.command == CMD_SCL) begin
			scl_low = ~t.scl_force_level;
			done    = 1'b1;
		end
		r.scl_drive_low = scl_low;
		r.sda_drive_low = sda_low;
		r.busy_res      = (cur_cmd != CMD_NONE);
		r.done_res      = done;
		r.read_byte     = rx_byte;
		r.nack          = nack_bit;
		r.scl_seen      = t.scl_in;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cfg    = PHASE_TICKS_RST;
			stretch_cfg  = STRETCH_LIMIT_RST;
			seq_step     = '0;
			cur_cmd      = CMD_NONE;
			bit_idx      = '0;
			shifter      = '0;
			delay_cnt    = '0;
			stretch_cnt  = '0;
			ack_sel      = 1'b0;
			rx_byte      = '0;
			nack_bit     = 1'b0;
			scl_low      = 1'b0;
			sda_low      = 1'b0;
			lines_due.delete();
			results_owed <= 0;
			engine_idle  <= 1'b1;
		end else begin
			if (res.valid && res.ready) begin
				seen.scl_drive_low = res.scl_drive_low;
				seen.sda_drive_low = res.sda_drive_low;
				seen.busy_res      = res.busy_res;
				seen.done_res      = res.done_res;
				seen.read_byte     = res.read_byte;
				seen.nack          = res.nack;
				seen.scl_seen      = res.scl_seen;
				if (lines_due.size() == 0) begin
					if (bad_count < 10)
						$display("%0t: unexpected res word %p", $time, seen);
					bad_count++;
				end else begin
					want = lines_due.pop_front();
					if (seen.scl_drive_low !== want.scl_drive_low ||
						seen.sda_drive_low !== want.sda_drive_low ||
						seen.busy_res !== want.busy_res ||
						seen.done_res !== want.done_res ||
						seen.read_byte !== want.read_byte ||
						seen.nack !== want.nack ||
						seen.scl_seen !== want.scl_seen) begin
						if (bad_count < 10)
							$display("%0t: res mismatch\n  expected %p\n  actual   %p",
								$time, want, seen);
						bad_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.idx == CFG_PHASE_TICKS)
					phase_cfg = cfg.wdata;
				else if (cfg.idx == CFG_STRETCH_LIMIT)
					stretch_cfg = cfg.wdata;
			end
			if (tick.valid && tick.ready) begin
				word_in.command         = tick.command;
				word_in.write_byte      = tick.write_byte;
				word_in.give_ack        = tick.give_ack;
				word_in.scl_force_level = tick.scl_force_level;
				word_in.scl_in          = tick.scl_in;
				word_in.sda_in          = tick.sda_in;
				lines_due.push_back(advance_engine(word_in));
			end
			results_owed <= lines_due.size();
			engine_idle  <= (cur_cmd == CMD_NONE);
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import i2cm_pkg::*;

	// unused command codes, must be dropped by the engine
	localparam logic [2:0] CODE_SPARE_LO = 3'd6;
	localparam logic [2:0] CODE_SPARE_HI = 3'd7;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 9;

	// random phases: phase_ticks, stretch_limit, tick words, idling on/off.
	// Zero phase_ticks and both extremes of stretch_limit; phase_ticks stays
	// small since every byte costs about 45 delay steps.
	logic [7:0] plan_ticks [PHASES] = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd3, 8'd6, 8'd1, 8'd5, 8'd1};
	logic [7:0] plan_limit [PHASES] = '{8'd0, 8'd3, 8'd255, 8'd17, 8'd100, 8'd1, 8'd2, 8'd50,
		8'd8};
	int         plan_words [PHASES] = '{50, 40, 50, 50, 40, 25, 50, 40, 60};
	bit         plan_idle  [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	i2cm_in_if  tick_if ();
	i2cm_out_if res_if ();
	i2cm_cfg_if cfg_if ();

	int   bad_words;
	int   owed;
	logic seq_idle;

	bit         idle_mode     = 1'b0;  // random gaps on tick valid and res ready
	bit         start_pending = 1'b0;  // launched a sequence, checker not caught up yet
	bit         in_frame      = 1'b0;  // between an accepted start and stop
	logic [7:0] cur_stretch   = STRETCH_LIMIT_RST;
	int         scl_hold_left = 0;     // remaining ticks of a slave holding SCL low

	i2c_master_byte_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	i2cm_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick_if),
		.res          (res_if),
		.cfg          (cfg_if),
		.mismatches   (bad_words),
		.results_owed (owed),
		.engine_idle  (seq_idle)
	);

	always #2 clk = ~clk;

	// Engine free to take a command on the next word. seq_idle is registered
	// in the checker, so a just-launched command is tracked here
	// until the checker reports busy.
	function automatic bit engine_free();
		if (!seq_idle)
			start_pending = 1'b0;
		return seq_idle && !start_pending;
	endfunction

	// random tick word; SCL sometimes held low in bursts to exercise stretching,
	// now and then longer than the stretch limit
	function automatic i2cm_tick_t rand_tick(input logic [2:0] code);
		i2cm_tick_t t;
		t.command         = code;
		t.write_byte      = 8'($urandom_range(0, 255));
		t.give_ack        = 1'($urandom_range(0, 1));
		t.scl_force_level = 1'($urandom_range(0, 1));
		t.sda_in          = 1'($urandom_range(0, 1));
		if (scl_hold_left > 0) begin
			t.scl_in = 1'b0;
			scl_hold_left--;
		end else if ($urandom_range(0, 99) < 4) begin
			if ($urandom_range(0, 3) == 0)
				scl_hold_left = $urandom_range(1, int'(cur_stretch) + 12);
			else
				scl_hold_left = $urandom_range(1, 6);
			t.scl_in = 1'b0;
		end else begin
			t.scl_in = ($urandom_range(0, 99) >= 3);
		end
		return t;
	endfunction

	// Mostly well-formed frames (start, writes/reads, stop) with some SCL
	// forcing and noise; commands sent while busy are dropped by the engine.
	function automatic logic [2:0] pick_code();
		int         r;
		logic [2:0] any_code;
		r        = $urandom_range(0, 99);
		any_code = 3'($urandom_range(0, 7));
		if (!engine_free())
			return (r < 8) ? any_code : CMD_NONE;
		if (r < 25)
			return CMD_NONE;
		if (r < 35)
			return any_code;
		if (r < 40)
			return CMD_SCL;
		if (!in_frame)
			return CMD_START;
		if (r < 68)
			return CMD_WRITE;
		if (r < 90)
			return CMD_READ;
		return CMD_STOP;
	endfunction

	// one tick word through the handshake; took = the command took effect
	task automatic put_tick(input i2cm_tick_t t, output bit took);
		bit ok;
		if (idle_mode && $urandom_range(0, 99) < 20) begin
			tick_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		ok = engine_free();
		tick_if.valid           <= 1'b1;
		tick_if.command         <= t.command;
		tick_if.write_byte      <= t.write_byte;
		tick_if.give_ack        <= t.give_ack;
		tick_if.scl_force_level <= t.scl_force_level;
		tick_if.scl_in          <= t.scl_in;
		tick_if.sda_in          <= t.sda_in;
		do @(posedge clk); while (!tick_if.ready);
		took = ok && t.command >= CMD_START && t.command <= CMD_SCL;
		if (took && t.command != CMD_SCL)
			start_pending = 1'b1;
	endtask

	// Directed command: issue it, then keep ticking with fixed line levels
	// until the sequence ends. noise goes into the command field meanwhile.
	// opt is give_ack for reads and the SCL level for set SCL.
	task automatic run_cmd(input logic [2:0] code, input logic [7:0] data, input logic opt,
		input logic [2:0] noise, input logic scl_lvl, input logic sda_lvl);
		i2cm_tick_t t;
		bit         took;
		t.command         = code;
		t.write_byte      = data;
		t.give_ack        = opt;
		t.scl_force_level = opt;
		t.scl_in          = scl_lvl;
		t.sda_in          = sda_lvl;
		put_tick(t, took);
		t.command    = noise;
		t.write_byte = ~data;
		while (!engine_free())
			put_tick(t, took);
	endtask

	task automatic random_phase(input int n_words);
		i2cm_tick_t t;
		bit         took;
		for (int k = 0; k < n_words; k++) begin
			t = rand_tick(pick_code());
			put_tick(t, took);
			if (took && t.command == CMD_START)
				in_frame = 1'b1;
			else if (took && t.command == CMD_STOP)
				in_frame = 1'b0;
		end
	endtask

	// let the running sequence finish, stop sending and drain all results;
	// the extra edges cover the input stage and the result register
	task automatic settle();
		bit took;
		while (!engine_free())
			put_tick(rand_tick(CMD_NONE), took);
		tick_if.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers, back to back on the cfg channel
	task automatic load_config(input logic [7:0] ticks, input logic [7:0] limit);
		cfg_if.valid <= 1'b1;
		cfg_if.idx   <= CFG_PHASE_TICKS;
		cfg_if.wdata <= ticks;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.idx   <= CFG_STRETCH_LIMIT;
		cfg_if.wdata <= limit;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		cur_stretch = limit;
	endtask

	// result side back-pressure: bursts of stalled cycles while idle_mode is set
	initial begin : ready_gen
		int hold;
		hold         = 0;
		res_if.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				res_if.ready <= (hold == 0);
			end else if (idle_mode && $urandom_range(0, 99) < 12) begin
				hold = $urandom_range(1, 8);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		tick_if.valid           = 1'b0;
		tick_if.command         = CMD_NONE;
		tick_if.write_byte      = 8'h00;
		tick_if.give_ack        = 1'b0;
		tick_if.scl_force_level = 1'b0;
		tick_if.scl_in          = 1'b1;
		tick_if.sda_in          = 1'b1;
		cfg_if.valid            = 1'b0;
		cfg_if.idx              = CFG_PHASE_TICKS;
		cfg_if.wdata            = 8'h00;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset config (phase_ticks 1, stretch_limit 100)
		idle_mode = 1'b1;
		run_cmd(CMD_SCL, 8'h00, 1'b0, CMD_NONE, 1'b1, 1'b1);      // pull SCL low
		run_cmd(CMD_SCL, 8'h00, 1'b1, CMD_NONE, 1'b1, 1'b1);      // release SCL
		run_cmd(CMD_START, 8'hFF, 1'b1, CMD_NONE, 1'b1, 1'b0);
		run_cmd(CMD_WRITE, 8'hFF, 1'b0, CMD_NONE, 1'b1, 1'b0);    // all ones, slave ACKs
		run_cmd(CMD_WRITE, 8'h00, 1'b1, CMD_READ, 1'b1, 1'b1);    // NACK; reads dropped while busy
		run_cmd(CMD_READ, 8'h00, 1'b1, CMD_NONE, 1'b1, 1'b1);     // 0xFF, master ACKs
		run_cmd(CMD_READ, 8'hFF, 1'b0, CMD_NONE, 1'b1, 1'b0);     // 0x00, master NACKs
		run_cmd(CODE_SPARE_LO, 8'hFF, 1'b1, CMD_NONE, 1'b1, 1'b1);
		run_cmd(CODE_SPARE_HI, 8'h00, 1'b0, CMD_NONE, 1'b1, 1'b1);
		run_cmd(CMD_WRITE, 8'h5A, 1'b0, CMD_NONE, 1'b0, 1'b0);    // SCL stuck low: stretch times out
		run_cmd(CMD_STOP, 8'h00, 1'b0, CMD_STOP, 1'b1, 1'b1);     // stop, stops dropped while busy
		settle();

		for (int p = 0; p < PHASES; p++) begin
			idle_mode = plan_idle[p] && (p != PHASES - 1);
			load_config(plan_ticks[p], plan_limit[p]);
			random_phase(plan_words[p]);
			settle();
		end

		if (bad_words == 0 && owed == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### i2c_master_byte_engine.f
src/i2cm_pkg.sv
src/i2cm_if.sv
src/i2cm_step.sv
src/i2c_master_byte_engine.sv
tb/i2cm_checker.sv
tb/testbench.sv
